>>> rtl/assert_macros.svh
// Assertion macros shared by the lock table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LKQ_ASSERT_IMPL(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lock table assertion failed");

// Check that a condition never holds outside reset.
`define LKQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("lock table forbidden condition");

`endif

>>> rtl/lkq_pkg.sv
// Shared types and constants of the lock table with wait queues.
package lkq_pkg;

    localparam int LOCK_ENTRIES_DEF = 64;
    localparam int CLIENT_COUNT_DEF = 16;

    localparam int LOCK_W   = 6;
    localparam int CLIENT_W = 4;
    localparam int XID_W    = 64;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 32;

    localparam logic [1:0] PH_FREE   = 2'd0;
    localparam logic [1:0] PH_LOCKED = 2'd1;
    localparam logic [1:0] PH_ACQ    = 2'd2;

    localparam logic [KIND_W-1:0] MSG_NONE       = 2'd0;
    localparam logic [KIND_W-1:0] MSG_RETRY      = 2'd1;
    localparam logic [KIND_W-1:0] MSG_REVOKE     = 2'd2;
    localparam logic [KIND_W-1:0] MSG_RETRY_WAIT = 2'd3;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_IGNORE,
        FIN_GRANT,
        FIN_OWNER,
        FIN_REVOKE,
        FIN_FREE,
        FIN_PASS
    } fin_t;

    typedef enum logic [1:0] {
        POS_SCAN,
        POS_TAIL,
        POS_HEAD
    } pos_t;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic ent_load;
        logic scan_clr;
        logic scan_inc;
        logic q_wr;
        logic append;
        pos_t pos;
        fin_t fin;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_rel;
        logic in_range;
        logic phase_free;
        logic owner_hit;
        logic xid_hit;
        logic cnt_zero;
        logic scan_hit;
        logic scan_last;
    } stat_t;

endpackage

>>> rtl/lkq_ctrl.sv
// Controller state machine of the lock table.
module lkq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lkq_pkg::stat_t stat,
    output lkq_pkg::cmd_t  cmd,
    output logic           busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LWAIT,
        S_LLOAD,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_APPEND,
        S_REVOKE,
        S_REL_RD,
        S_REL_PASS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd        = '0;
        cmd.pos    = lkq_pkg::POS_SCAN;
        cmd.fin    = lkq_pkg::FIN_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                state_next = S_LLOAD;
            end
            S_LLOAD:
            begin
                cmd.ent_load = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.in_range)
                begin
                    cmd.fin    = lkq_pkg::FIN_IGNORE;
                    state_next = S_IDLE;
                end
                else if (!stat.is_rel)
                begin
                    if (stat.phase_free)
                    begin
                        cmd.fin    = lkq_pkg::FIN_GRANT;
                        state_next = S_IDLE;
                    end
                    else if (stat.owner_hit)
                    begin
                        cmd.fin    = lkq_pkg::FIN_OWNER;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = stat.cnt_zero ? S_APPEND : S_SCAN_RD;
                    end
                end
                else
                begin
                    if (stat.phase_free || !stat.owner_hit || !stat.xid_hit)
                    begin
                        cmd.fin    = lkq_pkg::FIN_IGNORE;
                        state_next = S_IDLE;
                    end
                    else if (stat.cnt_zero)
                    begin
                        cmd.fin    = lkq_pkg::FIN_FREE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_REL_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.scan_hit)
                begin
                    cmd.q_wr   = 1'b1;
                    cmd.fin    = lkq_pkg::FIN_REVOKE;
                    state_next = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_APPEND:
            begin
                cmd.pos    = lkq_pkg::POS_TAIL;
                cmd.append = 1'b1;
                state_next = S_REVOKE;
            end
            S_REVOKE:
            begin
                cmd.fin    = lkq_pkg::FIN_REVOKE;
                state_next = S_IDLE;
            end
            S_REL_RD:
            begin
                cmd.pos    = lkq_pkg::POS_HEAD;
                state_next = S_REL_PASS;
            end
            S_REL_PASS:
            begin
                cmd.pos    = lkq_pkg::POS_HEAD;
                cmd.fin    = lkq_pkg::FIN_PASS;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);
    assign busy      = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

>>> rtl/lkq_dp.sv
// Datapath of the lock table: lock entries, wait queues, count and result word.
module lkq_dp
#(
    parameter int LOCK_ENTRIES = lkq_pkg::LOCK_ENTRIES_DEF,
    parameter int CLIENT_COUNT = lkq_pkg::CLIENT_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkq_pkg::cmd_t                  cmd,
    output lkq_pkg::stat_t                 stat,
    input  logic                           mode,
    input  logic [lkq_pkg::LOCK_W-1:0]     lock_id,
    input  logic [lkq_pkg::CLIENT_W-1:0]   client,
    input  logic [lkq_pkg::XID_W-1:0]      xid,
    output logic                           done,
    output logic [lkq_pkg::KIND_W-1:0]     msg_kind,
    output logic [lkq_pkg::CLIENT_W-1:0]   msg_client,
    output logic [lkq_pkg::LOCK_W-1:0]     msg_lock,
    output logic [lkq_pkg::XID_W-1:0]      msg_xid,
    output logic [lkq_pkg::COUNT_W-1:0]    acquire_count
);

    localparam int LW  = $clog2(LOCK_ENTRIES);
    localparam int CIW = $clog2(CLIENT_COUNT);
    localparam int CNW = CIW + 1;
    localparam int SW  = CIW + 2;
    localparam int QD  = LOCK_ENTRIES * CLIENT_COUNT;
    localparam int AW  = $clog2(QD);
    localparam int XW  = lkq_pkg::XID_W;

    typedef struct packed {
        logic [1:0]     phase;
        logic [CIW-1:0] owner;
        logic [XW-1:0]  oxid;
        logic [CIW-1:0] head;
        logic [CNW-1:0] count;
    } ent_t;

    typedef struct packed {
        logic [CIW-1:0] cl;
        logic [XW-1:0]  x;
    } qent_t;

    ent_t  lock_mem [LOCK_ENTRIES];
    qent_t q_mem    [QD];

    ent_t                          lock_rd_reg;
    qent_t                         q_rd_reg;
    ent_t                          ent_reg;
    logic                          mode_reg;
    logic [lkq_pkg::LOCK_W-1:0]    lk_reg;
    logic [lkq_pkg::CLIENT_W-1:0]  cl_reg;
    logic [XW-1:0]                 xid_reg;
    logic [CNW-1:0]                scan_reg;
    logic [LW-1:0]                 clr_reg;
    logic [lkq_pkg::COUNT_W-1:0]   total_reg;
    logic [lkq_pkg::COUNT_W-1:0]   total_next;
    logic                          done_reg;
    logic                          done_next;
    logic [lkq_pkg::KIND_W-1:0]    kind_reg;
    logic [lkq_pkg::KIND_W-1:0]    kind_next;
    logic [lkq_pkg::CLIENT_W-1:0]  mcl_reg;
    logic [lkq_pkg::CLIENT_W-1:0]  mcl_next;
    logic [lkq_pkg::LOCK_W-1:0]    mlk_reg;
    logic [lkq_pkg::LOCK_W-1:0]    mlk_next;
    logic [XW-1:0]                 mxid_reg;
    logic [XW-1:0]                 mxid_next;

    logic [LW-1:0]  lk_idx;
    logic [CIW-1:0] cl_idx;
    logic [CNW-1:0] pos;
    logic [SW-1:0]  slot_sum;
    logic [CIW-1:0] slot;
    logic [AW-1:0]  q_addr;
    logic           q_full;
    logic           q_we;
    qent_t          q_wdata;
    logic           lk_we;
    logic [LW-1:0]  lk_waddr;
    ent_t           lk_wdata;
    logic [CNW-1:0] cnt_dec;
    logic [CNW-1:0] head_sum;
    logic [lkq_pkg::COUNT_W-1:0] total_inc;
    logic [lkq_pkg::COUNT_W-1:0] total_dec;

    assign lk_idx = LW'(lk_reg);
    assign cl_idx = CIW'(cl_reg);

    always_comb
    begin
        case (cmd.pos)
            lkq_pkg::POS_SCAN: pos = scan_reg;
            lkq_pkg::POS_TAIL: pos = ent_reg.count;
            default:           pos = '0;
        endcase
    end

    assign slot_sum = SW'(ent_reg.head) + SW'(pos);
    assign slot     = (slot_sum >= SW'(CLIENT_COUNT)) ? CIW'(slot_sum - SW'(CLIENT_COUNT))
                                                      : CIW'(slot_sum);
    assign q_addr   = AW'(lk_idx) * AW'(CLIENT_COUNT) + AW'(slot);
    assign q_full   = (ent_reg.count == CNW'(CLIENT_COUNT));
    assign q_we     = cmd.q_wr || (cmd.append && !q_full);
    assign q_wdata  = '{cl: cl_idx, x: xid_reg};

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_addr] <= q_wdata;
        end
        q_rd_reg <= q_mem[q_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            lock_mem[lk_waddr] <= lk_wdata;
        end
        lock_rd_reg <= lock_mem[lk_idx];
    end

    assign cnt_dec   = ent_reg.count - CNW'(1);
    assign head_sum  = CNW'(ent_reg.head) + CNW'(1);
    assign total_inc = (total_reg != '1) ? total_reg + 1'b1 : total_reg;
    assign total_dec = (total_reg != '0) ? total_reg - 1'b1 : total_reg;

    always_comb
    begin
        lk_we      = 1'b0;
        lk_waddr   = lk_idx;
        lk_wdata   = ent_reg;
        total_next = total_reg;
        done_next  = 1'b0;
        kind_next  = lkq_pkg::MSG_NONE;
        mcl_next   = '0;
        mlk_next   = '0;
        mxid_next  = '0;
        if (cmd.clr_wr)
        begin
            lk_we    = 1'b1;
            lk_waddr = clr_reg;
            lk_wdata = '0;
        end
        case (cmd.fin)
            lkq_pkg::FIN_IGNORE:
            begin
                done_next = 1'b1;
            end
            lkq_pkg::FIN_GRANT:
            begin
                done_next      = 1'b1;
                total_next     = total_inc;
                lk_we          = 1'b1;
                lk_wdata.phase = lkq_pkg::PH_LOCKED;
                lk_wdata.owner = cl_idx;
                lk_wdata.oxid  = xid_reg;
                kind_next      = lkq_pkg::MSG_RETRY;
                mcl_next       = cl_reg;
                mlk_next       = lk_reg;
                mxid_next      = xid_reg;
            end
            lkq_pkg::FIN_OWNER:
            begin
                done_next  = 1'b1;
                total_next = total_inc;
            end
            lkq_pkg::FIN_REVOKE:
            begin
                done_next      = 1'b1;
                total_next     = total_inc;
                lk_we          = 1'b1;
                lk_wdata.phase = lkq_pkg::PH_ACQ;
                kind_next      = lkq_pkg::MSG_REVOKE;
                mcl_next       = lkq_pkg::CLIENT_W'(ent_reg.owner);
                mlk_next       = lk_reg;
                mxid_next      = ent_reg.oxid;
            end
            lkq_pkg::FIN_FREE:
            begin
                done_next      = 1'b1;
                total_next     = total_dec;
                lk_we          = 1'b1;
                lk_wdata.phase = lkq_pkg::PH_FREE;
                lk_wdata.owner = '0;
            end
            lkq_pkg::FIN_PASS:
            begin
                done_next      = 1'b1;
                total_next     = total_dec;
                lk_we          = 1'b1;
                lk_wdata.owner = q_rd_reg.cl;
                lk_wdata.oxid  = q_rd_reg.x;
                lk_wdata.count = cnt_dec;
                lk_wdata.head  = (head_sum >= CNW'(CLIENT_COUNT)) ? '0 : CIW'(head_sum);
                lk_wdata.phase = (cnt_dec == '0) ? lkq_pkg::PH_LOCKED : lkq_pkg::PH_ACQ;
                kind_next      = (cnt_dec == '0) ? lkq_pkg::MSG_RETRY
                                                 : lkq_pkg::MSG_RETRY_WAIT;
                mcl_next       = lkq_pkg::CLIENT_W'(q_rd_reg.cl);
                mlk_next       = lk_reg;
                mxid_next      = q_rd_reg.x;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            lk_reg   <= lock_id;
            cl_reg   <= client;
            xid_reg  <= xid;
        end
        if (cmd.ent_load)
        begin
            ent_reg <= lock_rd_reg;
        end
        else if (cmd.append && !q_full)
        begin
            ent_reg.count <= ent_reg.count + CNW'(1);
        end
        if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + CNW'(1);
        end
        if (cmd.fin != lkq_pkg::FIN_NONE)
        begin
            kind_reg <= kind_next;
            mcl_reg  <= mcl_next;
            mlk_reg  <= mlk_next;
            mxid_reg <= mxid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + LW'(1);
            end
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    assign stat.clr_last   = (clr_reg == LW'(LOCK_ENTRIES - 1));
    assign stat.is_rel     = mode_reg;
    assign stat.in_range   = (32'(lk_reg) < 32'(LOCK_ENTRIES))
                          && (32'(cl_reg) < 32'(CLIENT_COUNT));
    assign stat.phase_free = (ent_reg.phase == lkq_pkg::PH_FREE);
    assign stat.owner_hit  = (ent_reg.owner == cl_idx);
    assign stat.xid_hit    = (ent_reg.oxid == xid_reg);
    assign stat.cnt_zero   = (ent_reg.count == '0);
    assign stat.scan_hit   = (q_rd_reg.cl == cl_idx);
    assign stat.scan_last  = ((scan_reg + CNW'(1)) == ent_reg.count);

    assign done          = done_reg;
    assign msg_kind      = kind_reg;
    assign msg_client    = mcl_reg;
    assign msg_lock      = mlk_reg;
    assign msg_xid       = mxid_reg;
    assign acquire_count = total_reg;

endmodule

>>> rtl/lock_table_with_wait_queues_core.sv
// Top level of the lock table with per-lock wait queues.
//
//  channel   handshake             word
//  request   start / busy          mode, lock_id, client, xid
//  result    done (strobe)         msg_kind, msg_client, msg_lock, msg_xid, acquire_count
//
//  Each request is accepted in idle and its lock entry read and loaded. A grant, owner hit,
//  free or ignored request ends at the decision; a pass to the next waiter reads the queue
//  head; an acquire that must wait walks the waiting entries through the queue memory read
//  port, appends itself unless found, and revokes. After reset the block clears the lock
//  table with busy high. The done strobe lasts one cycle; the receiver cannot stall it.
`include "assert_macros.svh"

module lock_table_with_wait_queues_core
#(
    parameter int LOCK_ENTRIES = lkq_pkg::LOCK_ENTRIES_DEF,
    parameter int CLIENT_COUNT = lkq_pkg::CLIENT_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [lkq_pkg::LOCK_W-1:0]     lock_id,
    input  logic [lkq_pkg::CLIENT_W-1:0]   client,
    input  logic [lkq_pkg::XID_W-1:0]      xid,
    output logic                           done,
    output logic [lkq_pkg::KIND_W-1:0]     msg_kind,
    output logic [lkq_pkg::CLIENT_W-1:0]   msg_client,
    output logic [lkq_pkg::LOCK_W-1:0]     msg_lock,
    output logic [lkq_pkg::XID_W-1:0]      msg_xid,
    output logic [lkq_pkg::COUNT_W-1:0]    acquire_count
);

    lkq_pkg::cmd_t  cmd;
    lkq_pkg::stat_t stat;
    logic           none_dirty;

    lkq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    lkq_dp
    #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .CLIENT_COUNT (CLIENT_COUNT)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .lock_id       (lock_id),
        .client        (client),
        .xid           (xid),
        .done          (done),
        .msg_kind      (msg_kind),
        .msg_client    (msg_client),
        .msg_lock      (msg_lock),
        .msg_xid       (msg_xid),
        .acquire_count (acquire_count)
    );

    assign none_dirty = (msg_kind == lkq_pkg::MSG_NONE)
                     && (msg_client != '0 || msg_lock != '0 || msg_xid != '0);

    `LKQ_ASSERT_IMPL(a_accept_busy, clk, rst_n, start && !busy |=> busy)
    `LKQ_ASSERT_IMPL(a_single_done, clk, rst_n, done |=> !done)
    `LKQ_ASSERT_NEVER(a_none_clean, clk, rst_n, done && none_dirty)

endmodule
